// ===== sv/lru_dirty_block_buffer_defines.svh =====
// Assertion macros for the LRU dirty block buffer
`ifndef LRU_DIRTY_BLOCK_BUFFER_DEFINES_SVH
`define LRU_DIRTY_BLOCK_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LDBB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LDBB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ldbb_pkg.sv =====
// ----------------------------------------------------------------------------
// ldbb_pkg
// Operation, status and sequencer codes shared by the block buffer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldbb_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int TAG_W    = 32;
  localparam int CTR_W    = 32;
  localparam int PAYLD_W  = 64;

  localparam logic [OP_W-1:0] OP_GET   = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DFST  = 3'd2;
  localparam logic [OP_W-1:0] OP_DNXT  = 3'd3;
  localparam logic [OP_W-1:0] OP_EVICT = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CUR   = 6'b000010,
    ST_CURW  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

endpackage

// ===== sv/ldbb_ram.sv =====
// ----------------------------------------------------------------------------
// ldbb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lru_dirty_block_buffer.sv =====
// ----------------------------------------------------------------------------
// lru_dirty_block_buffer
// Tagged block table with LRU eviction and a dirty-block walk in list order.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_op, in_node, in_payload, in_mark_dirty
// out      output     out_valid/out_stall out_status, out_found_node,
//                                         out_found_payload, out_found_dirty
//
// A transaction steps through the states from acceptance: a table op scans every
// slot (ST_SCAN), then passes ST_DRAIN and ST_FIN, where the result is loaded;
// dirty next with a cursor first reads the cursor slot (ST_CUR, ST_CURW), and
// dirty next without a cursor or an undefined op goes straight to ST_FIN.
// The slot scan makes one RAM read per cycle through a single compare unit.
// Reset clears the valid bits, counters and the walk cursor; slot contents are
// not cleared. A stalled result holds the sequencer in its final state, and no
// new transaction is taken until the result is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_dirty_block_buffer #(
  parameter int ENTRIES    = 16,
  parameter int BLOCK_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ldbb_pkg::OP_W-1:0]      in_op,
  input  logic [ldbb_pkg::TAG_W-1:0]     in_node,
  input  logic [ldbb_pkg::PAYLD_W-1:0]   in_payload,
  input  logic                           in_mark_dirty,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ldbb_pkg::STATUS_W-1:0]  out_status,
  output logic [ldbb_pkg::TAG_W-1:0]     out_found_node,
  output logic [ldbb_pkg::PAYLD_W-1:0]   out_found_payload,
  output logic                           out_found_dirty
);

  import ldbb_pkg::*;

  `include "lru_dirty_block_buffer_defines.svh"

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TAG_LO = 0;
  localparam int STP_LO = TAG_W;
  localparam int POS_LO = TAG_W + CTR_W;
  localparam int DRT_B  = TAG_W + 2 * CTR_W;
  localparam int DAT_LO = DRT_B + 1;
  localparam int WORD_W = DAT_LO + BLOCK_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]       op_r;
  logic [TAG_W-1:0]      node_r;
  logic [BLOCK_BITS-1:0] pay_r;
  logic                  mark_r;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CTR_W-1:0]   use_ctr_r, use_ctr_nxt, pos_ctr_r, pos_ctr_nxt;
  logic               walk_v_r, walk_v_nxt;
  logic [IDX_W-1:0]   walk_slot_r, walk_slot_nxt;

  logic [IDX_W-1:0]  cnt_r;
  logic              pend_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [CTR_W-1:0]  cur_r;
  logic              follow_r;
  logic              best_v_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [WORD_W-1:0] best_w_r;
  logic              free_v_r;
  logic [IDX_W-1:0]  free_idx_r;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   sts_r, sts_nxt;
  logic [TAG_W-1:0]      fnode_r, fnode_nxt;
  logic [BLOCK_BITS-1:0] fdata_r, fdata_nxt;
  logic                  fdirty_r, fdirty_nxt;

  logic in_acc, fin_go;
  logic r_valid, take, r_lt_cur;
  logic [TAG_W-1:0] r_tag;
  logic [CTR_W-1:0] r_stp, r_pos, b_stp, b_pos;
  logic             r_drt;

  ldbb_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fin_go   = (state_r == ST_FIN) && !(out_valid_r && out_stall);
  assign ram_raddr = (state_r == ST_CUR) ? walk_slot_r : cnt_r;

  assign r_tag   = ram_rdata[TAG_LO +: TAG_W];
  assign r_stp   = ram_rdata[STP_LO +: CTR_W];
  assign r_pos   = ram_rdata[POS_LO +: CTR_W];
  assign r_drt   = ram_rdata[DRT_B];
  assign b_stp   = best_w_r[STP_LO +: CTR_W];
  assign b_pos   = best_w_r[POS_LO +: CTR_W];
  assign r_valid = valid_r[rd_idx_r];
  assign r_lt_cur = r_pos < cur_r;

  always_comb begin
    take = 1'b0;
    case (op_r)
      OP_GET, OP_PUT: take = r_valid && (r_tag == node_r) && !best_v_r;
      OP_DFST:  take = r_valid && r_drt && (!best_v_r || r_pos > b_pos);
      OP_DNXT:  take = r_valid && r_drt && r_lt_cur && (!best_v_r || r_pos > b_pos);
      OP_EVICT: take = r_valid && (!best_v_r || r_stp < b_stp ||
                                   (r_stp == b_stp && r_pos > b_pos));
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_DNXT) begin
            state_nxt = walk_v_r ? ST_CUR : ST_FIN;
          end else if (in_op == OP_GET || in_op == OP_PUT || in_op == OP_DFST ||
                       in_op == OP_EVICT) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_CUR:   state_nxt = ST_CURW;
      ST_CURW:  state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = (cnt_r == LAST_IDX) ? ST_DRAIN : ST_SCAN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   state_nxt = fin_go ? ST_IDLE : ST_FIN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sts_nxt       = STS_NONE;
    fnode_nxt     = '0;
    fdata_nxt     = '0;
    fdirty_nxt    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = best_idx_r;
    ram_wdata     = best_w_r;
    valid_nxt     = valid_r;
    use_ctr_nxt   = use_ctr_r;
    pos_ctr_nxt   = pos_ctr_r;
    walk_v_nxt    = walk_v_r;
    walk_slot_nxt = walk_slot_r;
    case (op_r)
      OP_GET: begin
        if (best_v_r) begin
          ram_we = 1'b1;
          ram_wdata[POS_LO +: CTR_W] = pos_ctr_r;
          ram_wdata[STP_LO +: CTR_W] = use_ctr_r;
          pos_ctr_nxt = pos_ctr_r + 1'b1;
          use_ctr_nxt = use_ctr_r + 1'b1;
          sts_nxt   = STS_OK;
          fnode_nxt = best_w_r[TAG_LO +: TAG_W];
          fdata_nxt = best_w_r[DAT_LO +: BLOCK_BITS];
        end
      end
      OP_PUT: begin
        walk_v_nxt = 1'b0;
        if (best_v_r) begin
          ram_we = 1'b1;
          ram_wdata[STP_LO +: CTR_W]      = use_ctr_r;
          ram_wdata[DRT_B]                = best_w_r[DRT_B] | mark_r;
          ram_wdata[DAT_LO +: BLOCK_BITS] = pay_r;
          use_ctr_nxt = use_ctr_r + 1'b1;
          sts_nxt = STS_OK;
        end else if (free_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx_r;
          ram_wdata = {pay_r, mark_r, pos_ctr_r, use_ctr_r, node_r};
          valid_nxt[free_idx_r] = 1'b1;
          use_ctr_nxt = use_ctr_r + 1'b1;
          pos_ctr_nxt = pos_ctr_r + 1'b1;
          sts_nxt = STS_OK;
        end else begin
          sts_nxt = STS_FULL;
        end
      end
      OP_DFST, OP_DNXT: begin
        if (op_r == OP_DFST || (walk_v_r && follow_r)) begin
          walk_v_nxt = best_v_r;
          if (best_v_r) begin
            walk_slot_nxt = best_idx_r;
            sts_nxt   = STS_OK;
            fnode_nxt = best_w_r[TAG_LO +: TAG_W];
            fdata_nxt = best_w_r[DAT_LO +: BLOCK_BITS];
          end
        end
      end
      OP_EVICT: begin
        if (best_v_r) begin
          valid_nxt[best_idx_r] = 1'b0;
          if (walk_v_r && walk_slot_r == best_idx_r) begin
            walk_v_nxt = 1'b0;
          end
          sts_nxt    = STS_OK;
          fnode_nxt  = best_w_r[TAG_LO +: TAG_W];
          fdata_nxt  = best_w_r[DAT_LO +: BLOCK_BITS];
          fdirty_nxt = best_w_r[DRT_B];
        end
      end
      default: sts_nxt = STS_NONE;
    endcase
    if (!fin_go) begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      use_ctr_r   <= '0;
      pos_ctr_r   <= '0;
      walk_v_r    <= 1'b0;
      walk_slot_r <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN);
      if (fin_go) begin
        valid_r     <= valid_nxt;
        use_ctr_r   <= use_ctr_nxt;
        pos_ctr_r   <= pos_ctr_nxt;
        walk_v_r    <= walk_v_nxt;
        walk_slot_r <= walk_slot_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op;
      node_r   <= in_node;
      pay_r    <= in_payload[BLOCK_BITS-1:0];
      mark_r   <= in_mark_dirty;
      cnt_r    <= '0;
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
      follow_r <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      cnt_r    <= cnt_r + 1'b1;
      rd_idx_r <= cnt_r;
    end
    if (state_r == ST_CURW) begin
      cur_r <= ram_rdata[POS_LO +: CTR_W];
    end
    if (pend_r) begin
      if (take) begin
        best_v_r   <= 1'b1;
        best_idx_r <= rd_idx_r;
        best_w_r   <= ram_rdata;
      end
      if (!r_valid && !free_v_r) begin
        free_v_r   <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (r_valid && r_lt_cur) begin
        follow_r <= 1'b1;
      end
    end
    if (fin_go) begin
      sts_r    <= sts_nxt;
      fnode_r  <= fnode_nxt;
      fdata_r  <= fdata_nxt;
      fdirty_r <= fdirty_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = sts_r;
  assign out_found_node    = fnode_r;
  assign out_found_payload = PAYLD_W'(fdata_r);
  assign out_found_dirty   = fdirty_r;

  `LDBB_ASSERT_NXT(a_out_only_from_fin, (state_r != ST_FIN) && !out_valid_r, !out_valid_r, "result without finish")
  `LDBB_ASSERT_IMP(a_full_is_bare, out_valid_r && (sts_r == STS_FULL), (fnode_r == '0) && !fdirty_r, "full result carries data")
  `LDBB_ASSERT_IMP(a_dirty_only_ok, out_valid_r && fdirty_r, sts_r == STS_OK, "dirty flag on failed result")
  `LDBB_ASSERT_NXT(a_busy_stalls, (state_r == ST_SCAN) && (cnt_r != LAST_IDX), in_stall, "input taken mid-scan")

endmodule

// ===== sim/lru_dirty_block_buffer_test.sv =====
// ----------------------------------------------------------------------------
// lru_dirty_block_buffer_test
// Self-checking bench for the block buffer. Directed cases, then random get,
// put, dirty walk, evict and undefined-op sequences over a small tag pool, are
// predicted by a behavioural table model and compared field by field with the returned transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_dirty_block_buffer_test;
  import ldbb_pkg::*;

  localparam int N_SLOTS = 16;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TAG_W-1:0]   node;
    logic [PAYLD_W-1:0] payload;
    logic               mark_dirty;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    node;
    logic [PAYLD_W-1:0]  payload;
    logic                dirty;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = '0;
  logic [TAG_W-1:0] in_node = '0;
  logic [PAYLD_W-1:0] in_payload = '0;
  logic in_mark_dirty = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0] out_found_node;
  logic [PAYLD_W-1:0] out_found_payload;
  logic out_found_dirty;

  request_t  pending_reqs[$];
  response_t expected_resps[$];
  int        fail_count = 0;
  bit        stim_done = 1'b0;

  logic              tbl_valid[N_SLOTS];
  logic [TAG_W-1:0]  tbl_tag[N_SLOTS];
  logic [PAYLD_W-1:0] tbl_data[N_SLOTS];
  logic              tbl_dirty[N_SLOTS];
  logic [CTR_W-1:0]  tbl_stamp[N_SLOTS];
  logic [CTR_W-1:0]  tbl_pos[N_SLOTS];
  logic [CTR_W-1:0]  stamp_ctr;
  logic [CTR_W-1:0]  pos_ctr;
  logic              cursor_valid;
  int                cursor_slot;

  lru_dirty_block_buffer u_dut (.*);

  always #1 clk = ~clk;

  function automatic int dirty_front(bit bounded, logic [CTR_W-1:0] lim);
    int best;
    best = -1;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (!tbl_valid[i] || !tbl_dirty[i]) continue;
      if (bounded && tbl_pos[i] >= lim) continue;
      if (best < 0 || tbl_pos[i] > tbl_pos[best]) best = i;
    end
    return best;
  endfunction

  function automatic response_t buffer_predict(request_t r);
    response_t res;
    int s;
    bit follower;
    res = '0;
    res.status = STS_NONE;
    s = -1;
    case (r.op)
      OP_GET: begin
        for (int i = 0; i < N_SLOTS; i++)
          if (s < 0 && tbl_valid[i] && tbl_tag[i] == r.node) s = i;
        if (s >= 0) begin
          tbl_pos[s] = pos_ctr++;
          tbl_stamp[s] = stamp_ctr++;
          res.status = STS_OK;
          res.node = tbl_tag[s];
          res.payload = tbl_data[s];
        end
      end
      OP_PUT: begin
        cursor_valid = 1'b0;
        for (int i = 0; i < N_SLOTS; i++)
          if (s < 0 && tbl_valid[i] && tbl_tag[i] == r.node) s = i;
        if (s < 0) begin
          for (int i = 0; i < N_SLOTS; i++)
            if (s < 0 && !tbl_valid[i]) s = i;
          if (s >= 0) begin
            tbl_valid[s] = 1'b1;
            tbl_tag[s] = r.node;
            tbl_dirty[s] = 1'b0;
            tbl_pos[s] = pos_ctr++;
          end
        end
        if (s < 0) res.status = STS_FULL;
        else begin
          tbl_stamp[s] = stamp_ctr++;
          if (r.mark_dirty) tbl_dirty[s] = 1'b1;
          tbl_data[s] = r.payload;
          res.status = STS_OK;
        end
      end
      OP_DFST: begin
        s = dirty_front(1'b0, '0);
        cursor_valid = s >= 0;
        if (s >= 0) begin
          cursor_slot = s;
          res.status = STS_OK;
          res.node = tbl_tag[s];
          res.payload = tbl_data[s];
        end
      end
      OP_DNXT: begin
        if (cursor_valid) begin
          follower = 1'b0;
          for (int i = 0; i < N_SLOTS; i++)
            if (tbl_valid[i] && tbl_pos[i] < tbl_pos[cursor_slot]) follower = 1'b1;
          if (follower) begin
            s = dirty_front(1'b1, tbl_pos[cursor_slot]);
            cursor_valid = s >= 0;
            if (s >= 0) begin
              cursor_slot = s;
              res.status = STS_OK;
              res.node = tbl_tag[s];
              res.payload = tbl_data[s];
            end
          end
        end
      end
      OP_EVICT: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (!tbl_valid[i]) continue;
          if (s < 0 || tbl_stamp[i] < tbl_stamp[s] ||
              (tbl_stamp[i] == tbl_stamp[s] && tbl_pos[i] > tbl_pos[s])) s = i;
        end
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          if (cursor_valid && cursor_slot == s) cursor_valid = 1'b0;
          res.status = STS_OK;
          res.node = tbl_tag[s];
          res.payload = tbl_data[s];
          res.dirty = tbl_dirty[s];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic request_t make_req(logic [OP_W-1:0] op, logic [TAG_W-1:0] node,
                                        logic [PAYLD_W-1:0] pl, logic md);
    request_t r;
    r.op = op;
    r.node = node;
    r.payload = pl;
    r.mark_dirty = md;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0: return {$urandom()};
      1: return '1;
      2: return '0;
      default: return TAG_W'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    logic [PAYLD_W-1:0] pl;
    int sel;
    for (int i = 0; i < N_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_tag[i] = '0;
      tbl_data[i] = '0;
      tbl_dirty[i] = 1'b0;
      tbl_stamp[i] = '0;
      tbl_pos[i] = '0;
    end
    stamp_ctr = '0;
    pos_ctr = '0;
    cursor_valid = 1'b0;
    cursor_slot = 0;

    pending_reqs.push_back(make_req(OP_EVICT, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_DFST, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_DNXT, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_GET, '1, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_PUT, '0, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_PUT, '1, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_PUT, 32'd5, 64'h5555_aaaa_5555_aaaa, 1'b1));
    pending_reqs.push_back(make_req(OP_PUT, '1, 64'haaaa_5555_aaaa_5555, 1'b0));
    pending_reqs.push_back(make_req(OP_DFST, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_DNXT, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_DNXT, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_GET, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(3'd5, '1, '1, 1'b1));
    pending_reqs.push_back(make_req(3'd6, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(3'd7, '1, '1, 1'b1));
    for (int i = 0; i < 17; i++)
      pending_reqs.push_back(make_req(OP_PUT, TAG_W'(100 + i), {$urandom(), $urandom()},
                                      1'(i % 2)));
    pending_reqs.push_back(make_req(OP_DFST, '0, '0, 1'b0));
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(make_req(OP_EVICT, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_DNXT, '0, '0, 1'b0));

    while (pending_reqs.size() < 1350) begin
      pl = {$urandom(), $urandom()};
      sel = $urandom_range(0, 99);
      if (sel < 35)
        pending_reqs.push_back(make_req(OP_PUT, pick_tag(), pl, 1'($urandom_range(0, 1))));
      else if (sel < 55)
        pending_reqs.push_back(make_req(OP_GET, pick_tag(), pl, 1'($urandom_range(0, 1))));
      else if (sel < 65)
        pending_reqs.push_back(make_req(OP_DFST, pick_tag(), pl, 1'($urandom_range(0, 1))));
      else if (sel < 70) begin
        pending_reqs.push_back(make_req(OP_DFST, '0, '0, 1'b0));
        repeat ($urandom_range(1, 6))
          pending_reqs.push_back(make_req(OP_DNXT, pick_tag(), pl, 1'b0));
      end else if (sel < 80)
        pending_reqs.push_back(make_req(OP_DNXT, pick_tag(), pl, 1'($urandom_range(0, 1))));
      else if (sel < 97)
        pending_reqs.push_back(make_req(OP_EVICT, pick_tag(), pl, 1'($urandom_range(0, 1))));
      else
        pending_reqs.push_back(make_req(OP_W'($urandom_range(5, 7)), pick_tag(), pl, 1'b1));
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  int drv_gap = 0;

  always @(posedge clk) begin
    request_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_resps.push_back(buffer_predict({in_op, in_node, in_payload, in_mark_dirty}));
        drv_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= nxt.op;
          in_node <= nxt.node;
          in_payload <= nxt.payload;
          in_mark_dirty <= nxt.mark_dirty;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int stall_left = 0;

  always @(posedge clk) begin
    response_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected transaction: status %0d", out_status);
          fail_count++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fail_count++;
          end
          if (out_found_node !== exp_r.node) begin
            $error("found_node: expected %h, got %h", exp_r.node, out_found_node);
            fail_count++;
          end
          if (out_found_payload !== exp_r.payload) begin
            $error("found_payload: expected %h, got %h", exp_r.payload, out_found_payload);
            fail_count++;
          end
          if (out_found_dirty !== exp_r.dirty) begin
            $error("found_dirty: expected %b, got %b", exp_r.dirty, out_found_dirty);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = gap_len();
        out_stall <= (stall_left > 0);
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
